// ----- rtl/lru_kvc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_kvc_pkg: shared types and constants
// Widths, command codes and the structs passed along the row of cache cells.
// ----------------------------------------------------------------------------
package lru_kvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // one stored pair
    typedef struct packed
    {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // broadcast to every cell
    typedef struct packed
    {
        logic             op_valid;
        logic             is_put;
        logic             any_hit;
        logic [KEY_W-1:0] key;
        logic [CAP_W-1:0] cap;
    } ctl_t;

endpackage
`default_nettype wire

// ----- rtl/lru_kvc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_kvc_cell: one recency position of the cache
// Holds one pair, compares it against the lookup key and takes the pair of
// its more recent neighbor when the row shifts.
// ----------------------------------------------------------------------------
module lru_kvc_cell
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  lru_kvc_pkg::ctl_t                     ctl,
    input  lru_kvc_pkg::entry_t                   left_entry,
    output lru_kvc_pkg::entry_t                   entry,
    input  wire  [lru_kvc_pkg::CAP_W-1:0]         pos_in,
    output logic [lru_kvc_pkg::CAP_W-1:0]         pos_out,
    input  wire                                   hit_in,
    output logic                                  hit_out,
    input  wire  [lru_kvc_pkg::VAL_W-1:0]         val_in,
    output logic [lru_kvc_pkg::VAL_W-1:0]         val_out,
    output logic                                  match
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lru_kvc_pkg::KEY_W-1:0] key_reg;
    logic [lru_kvc_pkg::VAL_W-1:0] value_reg;
    logic                          take_left;

    assign match   = valid_reg && (key_reg == ctl.key);
    assign hit_out = match || hit_in;
    assign val_out = match ? value_reg : val_in;
    assign pos_out = pos_in + lru_kvc_pkg::CAP_W'(1);

    // on a hit only the positions up to the hit shift; a new key shifts all
    assign take_left = ctl.op_valid &&
                       ((ctl.any_hit && hit_out) || (ctl.is_put && !ctl.any_hit));

    always_comb
    begin
        valid_next = valid_reg;
        if (take_left)
        begin
            if (ctl.any_hit)
                valid_next = left_entry.valid;
            else
                valid_next = left_entry.valid && (pos_in < ctl.cap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take_left)
        begin
            key_reg   <= left_entry.key;
            value_reg <= left_entry.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule
`default_nettype wire

// ----- rtl/lru_kvc_row.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_kvc_row: row of cache cells ordered by recency
// Cell 0 is the most recent entry. Hit flag and hit value travel from the
// least recent end toward cell 0; pairs move one cell toward the far end.
// ----------------------------------------------------------------------------
module lru_kvc_row
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  lru_kvc_pkg::ctl_t                     ctl,
    input  wire  [lru_kvc_pkg::VAL_W-1:0]         write_value,
    output logic                                  any_hit,
    output logic [lru_kvc_pkg::VAL_W-1:0]         hit_value
);

    localparam int N = lru_kvc_pkg::MAX_ENTRIES;

    lru_kvc_pkg::entry_t                 link [N+1];
    logic [lru_kvc_pkg::CAP_W-1:0]       pos_c [N+1];
    logic                                hit_c [N+1];
    logic [lru_kvc_pkg::VAL_W-1:0]       val_c [N+1];
    logic [N-1:0]                        match_vec;
    logic [N-1:0]                        valid_vec;

    assign hit_c[N]  = 1'b0;
    assign val_c[N]  = lru_kvc_pkg::MISS_VALUE;
    assign pos_c[0]  = '0;
    assign any_hit   = hit_c[0];
    assign hit_value = val_c[0];

    // pair entering at the most recent position
    assign link[0].valid = 1'b1;
    assign link[0].key   = ctl.key;
    assign link[0].value = ctl.is_put ? write_value : val_c[0];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            lru_kvc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_entry (link[g]),
                .entry      (link[g+1]),
                .pos_in     (pos_c[g]),
                .pos_out    (pos_c[g+1]),
                .hit_in     (hit_c[g+1]),
                .hit_out    (hit_c[g]),
                .val_in     (val_c[g+1]),
                .val_out    (val_c[g]),
                .match      (match_vec[g])
            );
            assign valid_vec[g] = link[g+1].valid;
        end
    endgenerate

    // keys are unique among stored entries
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op_valid |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // stored entries always fill the most recent positions without gaps
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + (N+1)'(1)))
        else $error("gap in the valid cells");

    // a hit moves the key to the most recent position
    a_hit_front: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op_valid && any_hit) |=> (link[1].valid && link[1].key == $past(ctl.key)))
        else $error("hit key not moved to the front");

endmodule
`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Channel table:
//   channel  signals                                  direction
//   command  start, busy, command, lookup_key,        in
//            write_value
//   result   done, hit, read_value                    out
//   config   cfg_valid, cfg_ready, cfg_data           in (capacity)
// One transaction per cycle: busy stays low, every cell compares, and any
// shift happens in the cycle a command is taken. A get returns its result on
// done in the next cycle; a put returns nothing. Reset clears all entries and
// sets the capacity to 16. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module lru_key_value_cache
(
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      start,
    output logic                                     busy,
    input  wire                                      command,
    input  wire  signed [lru_kvc_pkg::KEY_W-1:0]     lookup_key,
    input  wire  signed [lru_kvc_pkg::VAL_W-1:0]     write_value,
    output logic                                     done,
    output logic                                     hit,
    output logic signed [lru_kvc_pkg::VAL_W-1:0]     read_value,
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire         [lru_kvc_pkg::CFG_W-1:0]     cfg_data
);

    logic [lru_kvc_pkg::CFG_W-1:0] cfg_reg;
    logic [lru_kvc_pkg::CAP_W-1:0] cfg_ext;
    logic [lru_kvc_pkg::CAP_W-1:0] cap;
    logic                          accept;
    lru_kvc_pkg::ctl_t             ctl;
    logic                          any_hit;
    logic [lru_kvc_pkg::VAL_W-1:0] hit_value;
    logic                          done_reg;
    logic                          hit_reg;
    logic [lru_kvc_pkg::VAL_W-1:0] read_value_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // capacity saturates at the number of cells
    assign cfg_ext = lru_kvc_pkg::CAP_W'(cfg_reg);
    assign cap     = (cfg_ext > lru_kvc_pkg::CAP_W'(lru_kvc_pkg::MAX_ENTRIES))
                   ? lru_kvc_pkg::CAP_W'(lru_kvc_pkg::MAX_ENTRIES) : cfg_ext;

    assign ctl.op_valid = accept;
    assign ctl.is_put   = (lru_kvc_pkg::cmd_t'(command) == lru_kvc_pkg::CMD_PUT);
    assign ctl.any_hit  = any_hit;
    assign ctl.key      = lookup_key;
    assign ctl.cap      = cap;

    lru_kvc_row u_row
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .write_value (write_value),
        .any_hit     (any_hit),
        .hit_value   (hit_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= lru_kvc_pkg::CFG_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            done_reg <= accept && !ctl.is_put;
        end
    end

    // miss value comes out of the row as all ones
    always_ff @(posedge clk)
    begin
        if (accept && !ctl.is_put)
        begin
            hit_reg        <= any_hit;
            read_value_reg <= hit_value;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule
`default_nettype wire
